// ----- rtl/pdc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the packet deframer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pdc_pkg;

   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 11;
   localparam int HDR_DEPTH    = 12;
   localparam int MAX_PAYLOAD  = 512;
   localparam int LEN_W        = 16;
   localparam int SEQ_W        = 8;
   localparam int TS_W         = 32;
   localparam int TYPE_W       = 2;
   localparam int WIN_W        = 5;
   localparam int STATUS_W     = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 5;
   localparam int RSP_DATA_W   = 80;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 11'd2047;
   localparam logic [COUNT_W-1:0] ACK_MIN_N   = 11'd10;
   localparam logic [COUNT_W-1:0] DATA_MIN_N  = 11'd12;
   localparam logic [COUNT_W-1:0] PAYLOAD_IDX = 11'd12;
   localparam logic [COUNT_W-1:0] PCRC_IDX    = 11'd16;
   localparam logic [COUNT_W-1:0] HCRC_END    = 11'd8;
   localparam logic [COUNT_W-1:0] ACK_CRC_IDX = 11'd5;
   localparam logic [LEN_W:0]     FRAME_OVH   = 17'd16;
   localparam logic [BYTE_W-1:0]  TR_MASK     = 8'h20;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WINDOW = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_TYPE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TYPE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NACK_TYPE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK_TR    = 3'd4;

   // summary status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NO_HEADER = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INCONSIST = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_TYPE  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_WIN   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_BAD_CRC   = 3'd6;

   // one result as classified by the front end
   typedef struct packed {
      logic                summary;      // 0 payload byte, 1 end-of-packet summary
      logic [BYTE_W-1:0]   payload_byte;
      logic [TYPE_W-1:0]   pkt_type;
      logic                truncated;
      logic [WIN_W-1:0]    window;
      logic [LEN_W-1:0]    payload_length;
      logic [SEQ_W-1:0]    seqnum;
      logic [TS_W-1:0]     timestamp;
      logic                is_data;
      logic                is_ack;
      logic                short_ack;
      logic                short_data;
      logic                win_bad;
      logic                len_bad;
      logic                data_hcrc_bad;
      logic                ack_hcrc_bad;
      logic                pcrc_bad;
   } pdc_item_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                              input logic [BYTE_W-1:0] data);
      logic [31:0] c;
      c = crc ^ {24'b0, data};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/pdc_front.sv -----
// Front end: configuration registers, byte capture, running CRCs and classification.
// Depends on pdc_pkg; pushes one pdc_item_type per result into the queue.
`timescale 1ns / 1ps

module pdc_front
   import pdc_pkg::*;
#(
   parameter int MAX_PAYLOAD_LEN = MAX_PAYLOAD
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [BYTE_W-1:0]      in_byte,
   input  logic                   in_last,
   output logic                   push_valid,
   input  logic                   push_ready,
   output pdc_item_type           push_item
);

   logic [WIN_W-1:0]   max_window_ff;
   logic [TYPE_W-1:0]  data_code_ff;
   logic [TYPE_W-1:0]  ack_code_ff;
   logic [TYPE_W-1:0]  nack_code_ff;
   logic               mask_tr_ff;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0]  hdr_ff [HDR_DEPTH];
   logic [BYTE_W-1:0]  hdr_in [HDR_DEPTH];
   logic [31:0]        hcrc_ff, hcrc_in;
   logic [31:0]        crc6_ff, crc6_in;
   logic [31:0]        pcrc_ff, pcrc_in;
   logic [31:0]        trail_ff, trail_in;

   logic               accept;
   logic [BYTE_W-1:0]  crc_byte;
   logic [31:0]        hcrc_next;
   logic [TYPE_W-1:0]  ptype;
   logic               is_data, is_ack;
   logic [LEN_W-1:0]   length;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_window_ff <= 5'd31;
         data_code_ff  <= 2'd1;
         ack_code_ff   <= 2'd2;
         nack_code_ff  <= 2'd3;
         mask_tr_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_WINDOW: max_window_ff <= csr_wdata[WIN_W-1:0];
            CSR_DATA_TYPE:  data_code_ff  <= csr_wdata[TYPE_W-1:0];
            CSR_ACK_TYPE:   ack_code_ff   <= csr_wdata[TYPE_W-1:0];
            CSR_NACK_TYPE:  nack_code_ff  <= csr_wdata[TYPE_W-1:0];
            CSR_MASK_TR:    mask_tr_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign accept   = in_valid && push_ready;
   assign in_ready = push_ready;

   assign count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign crc_byte  = (count_ff == '0 && mask_tr_ff) ? (in_byte & ~TR_MASK) : in_byte;
   assign hcrc_next = crc32_byte(hcrc_ff, crc_byte);

   // header bytes with the current byte already in place
   always_comb begin
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_in[i] = (count_ff == COUNT_W'(i)) ? in_byte : hdr_ff[i];
      end
   end

   assign ptype   = hdr_in[0][7:6];
   assign is_data = (ptype == data_code_ff);
   assign is_ack  = (ptype == ack_code_ff) || (ptype == nack_code_ff);
   assign length  = is_data ? {hdr_in[1], hdr_in[2]} : '0;

   always_comb begin
      hcrc_in  = (count_ff < HCRC_END) ? hcrc_next : hcrc_ff;
      crc6_in  = (count_ff == ACK_CRC_IDX) ? hcrc_next : crc6_ff;
      pcrc_in  = pcrc_ff;
      trail_in = trail_ff;
      if (count_ff >= PAYLOAD_IDX) begin
         // the byte four places back leaves the trailer window into the payload CRC
         if (count_ff >= PCRC_IDX) begin
            pcrc_in = crc32_byte(pcrc_ff, trail_ff[31:24]);
         end
         trail_in = {trail_ff[23:0], in_byte};
      end
   end

   always_comb begin
      push_item                = '0;
      push_item.summary        = in_last;
      push_valid               = in_valid && (in_last || (count_ff >= PAYLOAD_IDX && is_data));
      if (!in_last) begin
         push_item.payload_byte = in_byte;
      end else begin
         push_item.pkt_type       = ptype;
         push_item.truncated      = hdr_in[0][5];
         push_item.window         = hdr_in[0][4:0];
         push_item.payload_length = length;
         if (is_data) begin
            push_item.seqnum    = hdr_in[3];
            push_item.timestamp = {hdr_in[7], hdr_in[6], hdr_in[5], hdr_in[4]};
         end else if (is_ack) begin
            push_item.seqnum    = hdr_in[1];
            push_item.timestamp = {hdr_in[5], hdr_in[4], hdr_in[3], hdr_in[2]};
         end
         push_item.is_data       = is_data;
         push_item.is_ack        = is_ack;
         push_item.short_ack     = count_in < ACK_MIN_N;
         push_item.short_data    = count_in < DATA_MIN_N;
         push_item.win_bad       = hdr_in[0][4:0] > max_window_ff;
         push_item.len_bad       = (({1'b0, length} + FRAME_OVH) != {6'b0, count_in})
                                   || ({1'b0, length} > (LEN_W + 1)'(MAX_PAYLOAD_LEN));
         push_item.data_hcrc_bad = (hcrc_ff ^ CRC_INIT)
                                   != {hdr_in[8], hdr_in[9], hdr_in[10], hdr_in[11]};
         push_item.ack_hcrc_bad  = (crc6_ff ^ CRC_INIT)
                                   != {hdr_in[6], hdr_in[7], hdr_in[8], hdr_in[9]};
         push_item.pcrc_bad      = (length != '0) && ((pcrc_in ^ CRC_INIT) != trail_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && in_last)) begin
         count_ff <= '0;
         hcrc_ff  <= CRC_INIT;
         crc6_ff  <= CRC_INIT;
         pcrc_ff  <= CRC_INIT;
         trail_ff <= '0;
         for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_ff[i] <= '0;
         end
      end else if (accept) begin
         count_ff <= count_in;
         hcrc_ff  <= hcrc_in;
         crc6_ff  <= crc6_in;
         pcrc_ff  <= pcrc_in;
         trail_ff <= trail_in;
         for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

endmodule

// ----- rtl/pdc_queue.sv -----
// Short queue of classified results between the front and back ends.
// Depends on pdc_pkg for the item type and depth.
`timescale 1ns / 1ps

module pdc_queue
   import pdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  pdc_item_type  push_item,
   output logic          pop_valid,
   input  logic          pop_ready,
   output pdc_item_type  pop_item
);

   pdc_item_type       mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]  count_ff;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- rtl/pdc_back.sv -----
// Back end: resolves the summary status in check order and holds the output register.
// Depends on pdc_pkg; drains the queue into the rsp_ stream.
`timescale 1ns / 1ps

module pdc_back
   import pdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  pdc_item_type          pop_item,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic                  rsp_valid_ff;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [STATUS_W-1:0]   status;

   assign pop_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (!pop_item.summary) begin
         status = ST_OK;
      end else if (pop_item.is_ack && pop_item.short_ack) begin
         status = ST_NO_HEADER;
      end else if (pop_item.is_data && pop_item.short_data) begin
         status = ST_NO_HEADER;
      end else if (!pop_item.is_data && pop_item.truncated) begin
         status = ST_INCONSIST;
      end else if (!pop_item.is_data && !pop_item.is_ack) begin
         status = ST_BAD_TYPE;
      end else if (pop_item.win_bad) begin
         status = ST_BAD_WIN;
      end else if (pop_item.is_data) begin
         if (pop_item.len_bad) begin
            status = ST_BAD_LEN;
         end else if (pop_item.data_hcrc_bad || pop_item.pcrc_bad) begin
            status = ST_BAD_CRC;
         end else begin
            status = ST_OK;
         end
      end else if (pop_item.ack_hcrc_bad) begin
         status = ST_BAD_CRC;
      end else begin
         status = ST_OK;
      end
   end

   assign rsp_kind_in = pop_item.summary;
   assign rsp_data_in = {5'b0, pop_item.timestamp, pop_item.seqnum, pop_item.payload_length,
                         pop_item.window, pop_item.truncated, pop_item.pkt_type, status,
                         pop_item.payload_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         rsp_valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/packet_deframer_crc32_check_unit.sv -----
// Top level of the packet deframer with header and payload CRC-32 checks.
// Depends on pdc_pkg, pdc_front, pdc_queue and pdc_back.
`timescale 1ns / 1ps

// Takes a received packet one byte per transaction on req_ (tlast on the final
// byte) and sustains one byte per clock while the queue has room. Payload bytes
// of a data packet (index 12 on, trailer included, final byte excluded) are
// forwarded with tuser 0; the final byte yields one summary with tuser 1
// carrying status and header fields. The front end updates the running CRC-32s
// and classifies combinationally, then a two-entry queue and the back end's
// output register hold each result, so either side can stall independently.
// The user must write registers through csr_ only between packets (unenforced).

module packet_deframer_crc32_check_unit
   import pdc_pkg::*;
#(
   parameter int MAX_PAYLOAD_LEN = MAX_PAYLOAD
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] in_byte
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] payload_byte, [10:8] status, [12:11] pkt_type, [13] truncated,
   // [18:14] window, [34:19] payload_length, [42:35] seqnum, [74:43] timestamp
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tuser    // [0] kind
);

   logic         push_valid, push_ready;
   pdc_item_type push_item;
   logic         pop_valid, pop_ready;
   pdc_item_type pop_item;

   pdc_front #(
      .MAX_PAYLOAD_LEN (MAX_PAYLOAD_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   pdc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   pdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
